@@ src/plin_pkg.sv @@
package plin_pkg;

    // fixed field widths of the request index and of point_count
    localparam int INDEX_BITS = 4;
    localparam int COUNT_BITS = 5;

    // point_count after reset
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd2;

    // request kinds carried on tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ src/plin_ram.sv @@
module plin_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // one read port, registered data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/plin_div.sv @@
module plin_div
    import plin_pkg::*;
#(
    parameter int NW = 50,
    parameter int DW = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output div_stat_t            stat,
    output logic signed [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_SIGN = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]        acc_reg, acc_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        dmag_reg, dmag_next;
    logic                 neg_reg, neg_next;
    logic signed [NW-1:0] quot_reg, quot_next;
    logic                 done_reg, done_next;

    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW:0]   trial;
    logic          fits;

    // operand magnitudes
    assign num_mag = num[NW-1] ? (~num + 1'b1) : num;
    assign den_mag = den[DW-1] ? (~den + 1'b1) : den;

    // restoring step: one quotient bit per cycle
    assign trial = {rem_reg, acc_reg[NW-1]};
    assign fits  = (trial >= {1'b0, dmag_reg});

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    acc_next   = num_mag;
                    dmag_next  = den_mag;
                    rem_next   = '0;
                    neg_next   = num[NW-1] ^ den[DW-1];
                    cnt_next   = CW'(NW);
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                rem_next = fits ? DW'(trial - {1'b0, dmag_reg}) : DW'(trial);
                acc_next = {acc_reg[NW-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = D_SIGN;
                end
            end
            D_SIGN: begin
                quot_next  = neg_reg ? (~acc_reg + 1'b1) : acc_reg;
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

@@ src/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator over a table of up to MAX_POINTS breakpoints.
// Input stream (s_*): tuser selects the request kind. A load request writes
// breakpoint (point_x, point_y) into slot point_index and returns nothing; a
// slot at or above MAX_POINTS is dropped. An evaluate request returns one
// y_value on the output stream (m_*), clamped to the end points outside the
// table and linearly interpolated inside it, truncating toward zero.
// Config channel (cfg_*): sets point_count; write it only while idle.
// A load never closes the input. With n the point_count limited to 1..MAX_POINTS,
// an evaluate closes the input until its result is in the output register. Its
// time is set by the table scan (one memory read per breakpoint, at most n)
// and the serial divider (one quotient bit per cycle over 2*VALUE_BITS + 2
// bits). A query clamped below the first x skips the scan and the divider.
// Results return in request order. The result sits in an output register, so
// a new request is taken while the previous result waits; when m_tready is
// low and a second result is ready, the block holds it and accepts nothing.
// Reset (aresetn low, synchronous) clears the control state and sets
// point_count to 2; the breakpoint table keeps no defined reset contents.
module piecewise_linear_interpolator
    import plin_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int VALUE_BITS = 24,
    localparam int IN_W  = ((INDEX_BITS + 3 * VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,  // point_index, point_x, point_y, query_x
    input  logic                  s_tuser,  // mode
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,  // y_value
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_BITS-1:0] cfg_data  // point_count
);

    localparam int VB = VALUE_BITS;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW = 2 * VB + 2;
    localparam int SW = PW + 1;

    localparam logic signed [SW-1:0] Y_MAX = {{(SW-VB+1){1'b0}}, {(VB-1){1'b1}}};
    localparam logic signed [SW-1:0] Y_MIN = {{(SW-VB+1){1'b1}}, {(VB-1){1'b0}}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIRST = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIVS  = 3'd4;
    localparam logic [2:0] ST_DIVW  = 3'd5;
    localparam logic [2:0] ST_ADD   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] n_reg, n_next;
    logic [COUNT_BITS-1:0] k_reg, k_next;
    logic signed [VB-1:0]  qx_reg, qx_next;
    logic signed [VB-1:0]  xl_reg, xl_next, yl_reg, yl_next;
    logic signed [VB-1:0]  xr_reg, xr_next, yr_reg, yr_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [VB:0]    den_reg, den_next;
    logic [VB-1:0]         res_reg, res_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [VB-1:0]         m_data_reg, m_data_next;

    // request fields
    logic [INDEX_BITS-1:0] in_index;
    logic signed [VB-1:0]  in_px, in_py, in_qx;
    logic                  s_accept;
    logic                  wr_en;

    // table access
    logic [AW-1:0]         rd_addr;
    logic [2*VB-1:0]       rd_data;
    logic signed [VB-1:0]  rd_x, rd_y;

    // arithmetic
    logic [COUNT_BITS-1:0] n_clamp;
    logic signed [VB:0]    dy, dx, den_c;
    logic signed [SW-1:0]  sum;
    logic                  div_start;
    div_stat_t             div_stat;
    logic signed [PW-1:0]  div_quot;

    assign in_index = s_tdata[INDEX_BITS-1:0];
    assign in_px    = s_tdata[INDEX_BITS +: VB];
    assign in_py    = s_tdata[INDEX_BITS + VB +: VB];
    assign in_qx    = s_tdata[INDEX_BITS + 2 * VB +: VB];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign wr_en    = s_accept && (s_tuser == MODE_LOAD) && (32'(in_index) < MAX_POINTS);

    assign cfg_ready = 1'b1;

    // breakpoint table: {y, x} per slot
    plin_ram #(
        .WIDTH (2 * VB),
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_index)),
        .wr_data ({in_py, in_px}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_x = rd_data[VB-1:0];
    assign rd_y = rd_data[2*VB-1:VB];

    // read slot 0 on accept, slot 1 after it, then one ahead of the scan
    always_comb begin
        case (state_reg)
            ST_IDLE:  rd_addr = '0;
            ST_FIRST: rd_addr = AW'(1);
            default:  rd_addr = AW'(k_reg + 1'b1);
        endcase
    end

    // count out of range: zero acts as one, large values as the table depth
    always_comb begin
        if (count_reg == '0) begin
            n_clamp = COUNT_BITS'(1);
        end else if (32'(count_reg) > MAX_POINTS) begin
            n_clamp = COUNT_BITS'(MAX_POINTS);
        end else begin
            n_clamp = count_reg;
        end
    end

    // segment differences
    assign dy    = (VB+1)'(yr_reg) - (VB+1)'(yl_reg);
    assign dx    = (VB+1)'(qx_reg) - (VB+1)'(xl_reg);
    assign den_c = (VB+1)'(xr_reg) - (VB+1)'(xl_reg);

    assign sum = SW'(yl_reg) + SW'(div_quot);

    assign div_start = (state_reg == ST_DIVS);

    plin_div #(
        .NW (PW),
        .DW (VB + 1)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg),
        .den     (den_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        qx_next       = qx_reg;
        xl_next       = xl_reg;
        yl_next       = yl_reg;
        xr_next       = xr_reg;
        yr_next       = yr_reg;
        prod_next     = prod_reg;
        den_next      = den_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            count_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == MODE_EVAL)) begin
                    qx_next    = in_qx;
                    n_next     = n_clamp;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                xl_next = rd_x;
                yl_next = rd_y;
                k_next  = COUNT_BITS'(1);
                if ((qx_reg < rd_x) || (n_reg == COUNT_BITS'(1))) begin
                    res_next   = rd_y;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (qx_reg <= rd_x) begin
                    xr_next = rd_x;
                    yr_next = rd_y;
                    if (qx_reg == xl_reg) begin
                        res_next   = yl_reg;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_MUL;
                    end
                end else if (k_reg == n_reg - 1'b1) begin
                    // past the last breakpoint
                    res_next   = rd_y;
                    state_next = ST_OUT;
                end else begin
                    xl_next = rd_x;
                    yl_next = rd_y;
                    k_next  = k_reg + 1'b1;
                end
            end
            ST_MUL: begin
                prod_next = PW'(dy) * PW'(dx);
                den_next  = den_c;
                if (den_c == '0) begin
                    res_next   = yl_reg;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS: begin
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_stat.done) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (sum > Y_MAX) begin
                    res_next = VB'(Y_MAX);
                end else if (sum < Y_MIN) begin
                    res_next = VB'(Y_MIN);
                end else begin
                    res_next = VB'(sum);
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= COUNT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        qx_reg     <= qx_next;
        xl_reg     <= xl_next;
        yl_reg     <= yl_next;
        xr_reg     <= xr_next;
        yr_reg     <= yr_next;
        prod_reg   <= prod_next;
        den_reg    <= den_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

`ifndef SYNTHESIS
    // an evaluate request closes the input until its result is parked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == MODE_EVAL)) |=> !s_tready)
        else $error("input open during evaluation");

    // a load never stalls the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == MODE_LOAD)) |=> s_tready)
        else $error("load stalled the input");

    // divider is only started when free
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // scan index stays inside the active table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (k_reg < n_reg))
        else $error("scan ran past point_count");

    // a new result only appears from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside output state");
`endif

endmodule
